### hw/rtl/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg
// Shared widths, register codes and reset values of the motion episode
// detector.
// ----------------------------------------------------------------------------
package med_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int DELTA_BITS  = SUM_BITS + 1;

  localparam int THR_BITS    = 18;
  localparam int STILL_BITS  = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_MOTION_THRESHOLD  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STILL_TIME_MS     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_MOTION_MS     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANSMIT_ON_ALARM = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_INDICATOR_ENABLE  = 3'd4;

  localparam logic [THR_BITS-1:0]   RST_MOTION_THRESHOLD = 18'd200;
  localparam logic [STILL_BITS-1:0] RST_STILL_TIME_MS    = 16'd1000;
  localparam logic [TIME_BITS-1:0]  RST_MIN_MOTION_MS    = '0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]          time_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

endpackage

### hw/rtl/med_if.sv
// ----------------------------------------------------------------------------
// med interfaces
// Valid/ready channels of the motion episode detector: sample input, result
// output and register write.
// ----------------------------------------------------------------------------
interface med_in_if import med_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t axis_x;
  sample_t axis_y;
  sample_t axis_z;
  time_t   time_ms;

  modport source (output valid, axis_x, axis_y, axis_z, time_ms, input ready);
  modport sink   (input valid, axis_x, axis_y, axis_z, time_ms, output ready);
endinterface

interface med_out_if import med_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  motion_now;
  logic  alarm_event;
  logic  false_alarm_event;
  time_t episode_length_ms;
  logic  moving_flag;
  logic  transmit_request;
  logic  indicator_level;

  modport source (output valid, motion_now, alarm_event, false_alarm_event,
                  episode_length_ms, moving_flag, transmit_request,
                  indicator_level, input ready);
  modport sink   (input valid, motion_now, alarm_event, false_alarm_event,
                  episode_length_ms, moving_flag, transmit_request,
                  indicator_level, output ready);
endinterface

interface med_cfg_if import med_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

### hw/rtl/motion_episode_detector.sv
// ----------------------------------------------------------------------------
// motion_episode_detector
// Accelerometer motion episode detector with alarm, sticky flag and indicator.
// ----------------------------------------------------------------------------
// One sample beat is taken every clock cycle while the result side keeps up.
// The sample is captured in an input register, and one pass of add, compare
// and subtract logic against the episode state produces the result register
// and the new state, so consecutive samples never wait on each other.
// The block stalls only when the result register is full and not being taken.
// Register writes are accepted in every cycle and apply to every sample that
// has not yet left the input register.
module motion_episode_detector import med_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  med_in_if.sink        in_chan,
  med_out_if.source     out_chan,
  med_cfg_if.sink       cfg_chan
);

  // configuration
  logic [THR_BITS-1:0]   thr_r;
  logic [STILL_BITS-1:0] still_time_r;
  time_t                 min_motion_r;
  logic                  tx_en_r;
  logic                  ind_en_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= RST_MOTION_THRESHOLD;
      still_time_r <= RST_STILL_TIME_MS;
      min_motion_r <= RST_MIN_MOTION_MS;
      tx_en_r      <= 1'b0;
      ind_en_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.addr)
        CFG_MOTION_THRESHOLD:  thr_r        <= cfg_chan.wdata[THR_BITS-1:0];
        CFG_STILL_TIME_MS:     still_time_r <= cfg_chan.wdata[STILL_BITS-1:0];
        CFG_MIN_MOTION_MS:     min_motion_r <= cfg_chan.wdata[TIME_BITS-1:0];
        CFG_TRANSMIT_ON_ALARM: tx_en_r      <= cfg_chan.wdata[0];
        CFG_INDICATOR_ENABLE:  ind_en_r     <= cfg_chan.wdata[0];
        default: ;
      endcase
    end
  end

  // input stage
  logic    s1_valid_r;
  sample_t s1_x_r, s1_y_r, s1_z_r;
  time_t   s1_time_r;
  logic    out_free;
  logic    advance;

  assign out_free      = !out_chan.valid || out_chan.ready;
  assign advance       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_x_r    <= in_chan.axis_x;
      s1_y_r    <= in_chan.axis_y;
      s1_z_r    <= in_chan.axis_z;
      s1_time_r <= in_chan.time_ms;
    end
  end

  // episode state
  sum_t  prev_sum_r,  prev_sum_nxt;
  time_t mstart_r,    mstart_nxt;
  logic  mvalid_r,    mvalid_nxt;
  time_t sstart_r,    sstart_nxt;
  logic  svalid_r,    svalid_nxt;
  logic  moving_r,    moving_nxt;
  logic  ind_r,       ind_nxt;

  sum_t                    sum;
  logic signed [DELTA_BITS-1:0] delta;
  logic [DELTA_BITS-1:0]   mag;
  logic                    motion;
  time_t                   still_elapsed;
  logic                    still_over;
  logic                    alarm;
  logic                    false_alarm;
  time_t                   length;

  always_comb begin
    sum = SUM_BITS'(s1_x_r) + SUM_BITS'(s1_y_r) + SUM_BITS'(s1_z_r);
    delta = DELTA_BITS'(sum) - DELTA_BITS'(prev_sum_r);
    mag = delta[DELTA_BITS-1] ? DELTA_BITS'(-delta) : DELTA_BITS'(delta);
    motion = mag > DELTA_BITS'(thr_r);
    still_elapsed = svalid_r ? (s1_time_r - sstart_r) : '0;
    still_over = still_elapsed > TIME_BITS'(still_time_r);

    prev_sum_nxt = sum;
    mstart_nxt   = mstart_r;
    mvalid_nxt   = mvalid_r;
    sstart_nxt   = sstart_r;
    svalid_nxt   = svalid_r;
    moving_nxt   = moving_r;
    ind_nxt      = ind_r;
    alarm        = 1'b0;
    false_alarm  = 1'b0;
    length       = '0;

    if (motion) begin
      svalid_nxt = 1'b0;
      if (!mvalid_r) begin
        mstart_nxt = s1_time_r;
        mvalid_nxt = 1'b1;
      end
    end else begin
      if (!svalid_r) begin
        sstart_nxt = s1_time_r;
        svalid_nxt = 1'b1;
      end
      if (still_over) begin
        svalid_nxt = 1'b0;
        if (mvalid_r) begin
          length     = s1_time_r - mstart_r;
          mvalid_nxt = 1'b0;
          if (length < min_motion_r) begin
            false_alarm = 1'b1;
            if (ind_en_r) ind_nxt = 1'b0;
          end else begin
            alarm      = 1'b1;
            moving_nxt = 1'b1;
            if (ind_en_r) ind_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sum_r <= '0;
      mstart_r   <= '0;
      mvalid_r   <= 1'b0;
      sstart_r   <= '0;
      svalid_r   <= 1'b0;
      moving_r   <= 1'b0;
      ind_r      <= 1'b0;
    end else if (advance) begin
      prev_sum_r <= prev_sum_nxt;
      mstart_r   <= mstart_nxt;
      mvalid_r   <= mvalid_nxt;
      sstart_r   <= sstart_nxt;
      svalid_r   <= svalid_nxt;
      moving_r   <= moving_nxt;
      ind_r      <= ind_nxt;
    end
  end

  // result register
  logic out_valid_r;

  assign out_chan.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_chan.motion_now        <= motion;
      out_chan.alarm_event       <= alarm;
      out_chan.false_alarm_event <= false_alarm;
      out_chan.episode_length_ms <= length;
      out_chan.moving_flag       <= moving_nxt;
      out_chan.transmit_request  <= alarm && tx_en_r;
      out_chan.indicator_level   <= ind_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_chan.alarm_event && out_chan.false_alarm_event))
    else $error("alarm and false alarm in one beat");

  a_motion_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.motion_now) |->
      (!out_chan.alarm_event && !out_chan.false_alarm_event))
    else $error("episode closed on a motion sample");

  a_tx_needs_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.transmit_request) |-> out_chan.alarm_event)
    else $error("transmit request without alarm");

  a_moving_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(moving_r))
    else $error("moving flag cleared outside reset");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> $stable(mvalid_r) && $stable(prev_sum_r))
    else $error("episode state changed while stalled");
`endif

endmodule

### test/tb_motion_episode_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motion_episode_detector
// Self-checking regression of the motion episode detector. A behavioural
// episode tracker predicts every result beat from the accepted samples and
// the register settings; a monitor compares each result beat field by field.
// Directed samples cover thresholds, sample extremes, timestamp wrap and the
// register extremes, then randomised episodes and noise run under several
// register settings with bursty input, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module tb_motion_episode_detector;
  import med_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef enum {RECV_ALWAYS, RECV_RANDOM, RECV_PATTERN, RECV_SPARSE} recv_mode_t;

  typedef struct packed {
    logic  motion_now;
    logic  alarm_event;
    logic  false_alarm_event;
    time_t episode_length_ms;
    logic  moving_flag;
    logic  transmit_request;
    logic  indicator_level;
  } episode_result_t;

  logic clk = 1'b0;
  logic rst_n;

  med_in_if  in_bus ();
  med_out_if out_bus ();
  med_cfg_if cfg_bus ();

  motion_episode_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #5 clk = ~clk;

  // register copies
  logic [THR_BITS-1:0]   reg_threshold;
  logic [STILL_BITS-1:0] reg_still_ms;
  time_t                 reg_min_ms;
  logic                  reg_transmit;
  logic                  reg_indicator_en;

  // episode tracker state
  sum_t  trk_prev_sum;
  time_t trk_episode_t0;
  logic  trk_episode_open;
  time_t trk_still_t0;
  logic  trk_still_open;
  logic  trk_moving;
  logic  trk_indicator;

  episode_result_t pending_results[$];
  episode_result_t seen_beat;
  episode_result_t due_beat;

  int         mismatches  = 0;
  int         samples_sent = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;
  int         gap_max     = 0;
  recv_mode_t recv_mode   = RECV_ALWAYS;
  int         hold_asked  = 0;
  int         hold_done   = 0;
  int         hold_left   = 0;
  int         rcv_tick    = 0;
  time_t      wall_ms     = '0;

  function automatic episode_result_t track_episode(sample_t ax, sample_t ay, sample_t az,
                                                    time_t now);
    sum_t                         total;
    logic signed [DELTA_BITS-1:0] diff;
    logic [DELTA_BITS-1:0]        change;
    episode_result_t              r;
    r = '0;
    total = sum_t'(ax) + sum_t'(ay) + sum_t'(az);
    diff = DELTA_BITS'(total) - DELTA_BITS'(trk_prev_sum);
    change = diff[DELTA_BITS-1] ? -diff : diff;
    r.motion_now = change > DELTA_BITS'(reg_threshold);
    trk_prev_sum = total;
    if (r.motion_now) begin
      trk_still_open = 1'b0;
      if (!trk_episode_open) begin
        trk_episode_t0 = now;
        trk_episode_open = 1'b1;
      end
    end else begin
      if (!trk_still_open) begin
        trk_still_t0 = now;
        trk_still_open = 1'b1;
      end
      if (time_t'(now - trk_still_t0) > {16'b0, reg_still_ms}) begin
        trk_still_open = 1'b0;
        if (trk_episode_open) begin
          r.episode_length_ms = now - trk_episode_t0;
          trk_episode_open = 1'b0;
          if (r.episode_length_ms < reg_min_ms) begin
            r.false_alarm_event = 1'b1;
            if (reg_indicator_en) trk_indicator = 1'b0;
          end else begin
            r.alarm_event = 1'b1;
            trk_moving = 1'b1;
            if (reg_indicator_en) trk_indicator = 1'b1;
          end
        end
      end
    end
    r.moving_flag = trk_moving;
    r.transmit_request = r.alarm_event & reg_transmit;
    r.indicator_level = trk_indicator;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_beat = '{out_bus.motion_now, out_bus.alarm_event, out_bus.false_alarm_event,
                    out_bus.episode_length_ms, out_bus.moving_flag, out_bus.transmit_request,
                    out_bus.indicator_level};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, expected nothing, actual %p",
                 $time, seen_beat);
      end else begin
        due_beat = pending_results.pop_front();
        compare_field("motion_now", due_beat.motion_now, seen_beat.motion_now);
        compare_field("alarm_event", due_beat.alarm_event, seen_beat.alarm_event);
        compare_field("false_alarm_event", due_beat.false_alarm_event,
                      seen_beat.false_alarm_event);
        compare_field("episode_length_ms", due_beat.episode_length_ms,
                      seen_beat.episode_length_ms);
        compare_field("moving_flag", due_beat.moving_flag, seen_beat.moving_flag);
        compare_field("transmit_request", due_beat.transmit_request,
                      seen_beat.transmit_request);
        compare_field("indicator_level", due_beat.indicator_level, seen_beat.indicator_level);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("motion_episode_detector regression: fail");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      rcv_tick++;
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (recv_mode)
          RECV_ALWAYS:  out_bus.ready <= 1'b1;
          RECV_RANDOM:  out_bus.ready <= ($urandom_range(0, 9) < 7);
          RECV_PATTERN: out_bus.ready <= (rcv_tick % 5 != 0);
          default:      out_bus.ready <= (rcv_tick % 8 == 0);
        endcase
      end
    end
  end

  task automatic offer_sample(input sample_t ax, input sample_t ay, input sample_t az,
                              input time_t ts);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.axis_x  <= ax;
    in_bus.axis_y  <= ay;
    in_bus.axis_z  <= az;
    in_bus.time_ms <= ts;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(track_episode(ax, ay, az, ts));
    samples_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.wdata <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_MOTION_THRESHOLD:  reg_threshold = data[THR_BITS-1:0];
      CFG_STILL_TIME_MS:     reg_still_ms = data[STILL_BITS-1:0];
      CFG_MIN_MOTION_MS:     reg_min_ms = data[TIME_BITS-1:0];
      CFG_TRANSMIT_ON_ALARM: reg_transmit = data[0];
      CFG_INDICATOR_ENABLE:  reg_indicator_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // swinging motion beats, then stillness that runs out
  task automatic send_episode();
    sample_t bx, by, bz;
    time_t   still_base;
    int      swing, nudge, cap;
    bit      up;
    up = $urandom_range(0, 1);
    bx = '0;
    by = sample_t'(int'($urandom_range(0, 4000)) - 2000);
    bz = sample_t'(int'($urandom_range(0, 4000)) - 2000);
    repeat ($urandom_range(1, 6)) begin
      swing = 20000 + int'($urandom_range(0, 8000));
      bx = up ? sample_t'(swing) : sample_t'(-swing);
      up = !up;
      wall_ms += $urandom_range(0, reg_still_ms + 50);
      offer_sample(bx, by, bz, wall_ms);
    end
    cap = (reg_threshold / 4 > 1000) ? 1000 : int'(reg_threshold / 4);
    wall_ms += $urandom_range(0, reg_still_ms);
    still_base = wall_ms;
    offer_sample(bx, by, bz, wall_ms);
    repeat ($urandom_range(0, 3)) begin
      nudge = int'($urandom_range(0, cap));
      wall_ms += $urandom_range(0, reg_still_ms / 4);
      offer_sample(bx, by, $urandom_range(0, 1) ? sample_t'(bz + nudge) : sample_t'(bz - nudge),
                   wall_ms);
    end
    if ($urandom_range(0, 3) == 0) begin
      wall_ms = still_base + reg_still_ms;
      offer_sample(bx, by, bz, wall_ms);
    end
    wall_ms = still_base + reg_still_ms + $urandom_range(1, 20);
    offer_sample(bx, by, bz, wall_ms);
  endtask

  task automatic test_first_sample_and_thresholds();
    gap_max = 2;
    recv_mode = RECV_RANDOM;
    offer_sample(16'sd0, 16'sd0, 16'sd201, 32'd0);
    offer_sample(16'sd0, 16'sd0, 16'sd1, 32'd10);
    offer_sample(16'sd0, 16'sd0, 16'sd1, 32'd1010);
    offer_sample(16'sd0, 16'sd0, 16'sd1, 32'd1011);
  endtask

  task automatic test_extreme_samples();
    offer_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd2000);
    offer_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd2001);
    offer_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd2002);
    offer_sample(16'sh7FFF, 16'sh8000, 16'sd0, 32'd2003);
    offer_sample(16'sh7FFF, 16'sh8000, 16'sd0, 32'd2004);
    offer_sample(16'sh7FFF, 16'sh8000, 16'sd0, 32'd3005);
  endtask

  task automatic test_timestamp_wrap();
    write_register(CFG_STILL_TIME_MS, 32'd10);
    write_register(CFG_MIN_MOTION_MS, 32'd50);
    offer_sample(16'sd0, 16'sd0, 16'sd500, 32'hFFFF_FFF0);
    offer_sample(16'sd0, 16'sd0, 16'sd500, 32'hFFFF_FFFC);
    offer_sample(16'sd0, 16'sd0, 16'sd500, 32'h0000_0007);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_MOTION_THRESHOLD, 32'hFFFF_FFFF);
    write_register(CFG_STILL_TIME_MS, 32'hFFFF_0000);
    write_register(CFG_MIN_MOTION_MS, 32'hFFFF_FFFF);
    write_register(CFG_TRANSMIT_ON_ALARM, 32'hFFFF_FFFF);
    write_register(CFG_INDICATOR_ENABLE, 32'h0000_0001);
    for (int i = CFG_INDICATOR_ENABLE + 1; i < 2 ** CFG_ADDR_W; i++)
      write_register(CFG_ADDR_W'(i), $urandom);
    // stillness runs out with no episode open
    offer_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd5000);
    offer_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd5001);
    write_register(CFG_MOTION_THRESHOLD, 32'hFFFC_0000);
    offer_sample(16'sd0, 16'sd0, 16'sd1, 32'd5002);
    offer_sample(16'sd0, 16'sd0, 16'sd1, 32'd5003);
    offer_sample(16'sd0, 16'sd0, 16'sd1, 32'd5004);
    write_register(CFG_MIN_MOTION_MS, 32'd0);
    offer_sample(16'sd0, 16'sd0, 16'sd2, 32'd5005);
    offer_sample(16'sd0, 16'sd0, 16'sd2, 32'd5006);
    offer_sample(16'sd0, 16'sd0, 16'sd2, 32'd5007);
    // indicator disabled holds its level through a false alarm
    write_register(CFG_INDICATOR_ENABLE, 32'hFFFF_FFFE);
    write_register(CFG_MIN_MOTION_MS, 32'd100);
    offer_sample(16'sd0, 16'sd0, 16'sd3, 32'd5008);
    offer_sample(16'sd0, 16'sd0, 16'sd3, 32'd5009);
    offer_sample(16'sd0, 16'sd0, 16'sd3, 32'd5010);
    write_register(CFG_STILL_TIME_MS, 32'h0000_FFFF);
    offer_sample(16'sd0, 16'sd0, 16'sd4, 32'd6000);
    offer_sample(16'sd0, 16'sd0, 16'sd4, 32'd6001);
    offer_sample(16'sd0, 16'sd0, 16'sd4, 32'd6001 + 32'd65535);
    offer_sample(16'sd0, 16'sd0, 16'sd4, 32'd6001 + 32'd65536);
  endtask

  task automatic test_backpressure();
    int stop_at;
    write_register(CFG_MOTION_THRESHOLD, 32'd200);
    write_register(CFG_STILL_TIME_MS, 32'd50);
    write_register(CFG_MIN_MOTION_MS, 32'd100);
    write_register(CFG_TRANSMIT_ON_ALARM, 32'd1);
    write_register(CFG_INDICATOR_ENABLE, 32'd1);
    gap_max = 0;
    recv_mode = RECV_ALWAYS;
    hold_asked++;
    stop_at = samples_sent + 60;
    while (samples_sent < stop_at) send_episode();
  endtask

  task automatic test_random_episodes();
    logic [THR_BITS-1:0]   thr;
    logic [STILL_BITS-1:0] still;
    time_t                 min_ms;
    int                    stop_at;
    for (int p = 0; p < 8; p++) begin
      thr = (p == 6) ? '1 : (p == 1) ? '0 : THR_BITS'($urandom_range(0, 4000));
      still = (p == 2) ? '0 : (p == 4) ? '1 : STILL_BITS'($urandom_range(0, 300));
      min_ms = (p == 7) ? '1 : (p == 0) ? '0 : time_t'($urandom_range(0, 3 * still + 400));
      write_register(CFG_MOTION_THRESHOLD, {14'($urandom), thr});
      write_register(CFG_STILL_TIME_MS, {16'($urandom), still});
      write_register(CFG_MIN_MOTION_MS, min_ms);
      write_register(CFG_TRANSMIT_ON_ALARM, $urandom);
      write_register(CFG_INDICATOR_ENABLE, $urandom);
      gap_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 4 : 12;
      recv_mode = recv_mode_t'(p % 4);
      if (p == 3) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      stop_at = samples_sent + 160;
      while (samples_sent < stop_at) begin
        if ($urandom_range(0, 9) < 7) begin
          send_episode();
        end else begin
          repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 7) == 0) wall_ms = $urandom;
            else wall_ms += $urandom_range(0, 2 * reg_still_ms + 10);
            offer_sample(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom), wall_ms);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.axis_x = '0;
    in_bus.axis_y = '0;
    in_bus.axis_z = '0;
    in_bus.time_ms = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = '0;
    cfg_bus.wdata = '0;
    reg_threshold = RST_MOTION_THRESHOLD;
    reg_still_ms = RST_STILL_TIME_MS;
    reg_min_ms = RST_MIN_MOTION_MS;
    reg_transmit = 1'b0;
    reg_indicator_en = 1'b0;
    trk_prev_sum = '0;
    trk_episode_t0 = '0;
    trk_episode_open = 1'b0;
    trk_still_t0 = '0;
    trk_still_open = 1'b0;
    trk_moving = 1'b0;
    trk_indicator = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_sample_and_thresholds();
    test_extreme_samples();
    test_timestamp_wrap();
    test_register_extremes();
    test_backpressure();
    test_random_episodes();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("motion_episode_detector regression: pass");
    end else begin
      $display("motion_episode_detector regression: fail");
    end
    $finish;
  end

endmodule
